// ----- rtl/cbpu_pkg.sv -----
// cbpu_pkg: shared types and constants for the CB-prefix bit operation unit.
// No dependencies.
`timescale 1ns / 1ps
package cbpu_pkg;

  typedef enum logic [1:0] {
    GRP_SHIFT = 2'd0,
    GRP_BIT   = 2'd1,
    GRP_RES   = 2'd2,
    GRP_SET   = 2'd3
  } grp_e;

  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_op_e;

  localparam logic [2:0] TargetMem    = 3'd6;
  localparam logic [4:0] CyclesMem    = 5'd16;
  localparam logic [4:0] CyclesReg    = 5'd8;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [7:0] value;
    logic       write_back;
    logic       is_mem;
    logic [2:0] target;
    flags_t     flags;
    logic [4:0] cycles;
  } result_t;

endpackage

// ----- rtl/cbpu_exec.sv -----
// cbpu_exec: combinational execute of one CB-prefix instruction.
// Depends on cbpu_pkg.
`timescale 1ns / 1ps
module cbpu_exec (
  input  logic [7:0]       command_i,
  input  logic [7:0]       operand_i,
  input  cbpu_pkg::flags_t flags_i,
  output cbpu_pkg::result_t result_o
);
  import cbpu_pkg::*;

  grp_e       grp;
  shift_op_e  sop;
  logic [2:0] mid;
  logic [2:0] tgt;
  logic [7:0] v;
  logic [7:0] mask;
  logic [7:0] sh_val;
  logic       sh_c;

  assign grp  = grp_e'(command_i[7:6]);
  assign mid  = command_i[5:3];
  assign sop  = shift_op_e'(mid);
  assign tgt  = command_i[2:0];
  assign v    = operand_i;
  assign mask = 8'd1 << mid;

  always_comb begin
    case (sop)
      SH_RLC:  begin sh_c = v[7]; sh_val = {v[6:0], v[7]}; end
      SH_RRC:  begin sh_c = v[0]; sh_val = {v[0], v[7:1]}; end
      SH_RL:   begin sh_c = v[7]; sh_val = {v[6:0], flags_i.c}; end
      SH_RR:   begin sh_c = v[0]; sh_val = {flags_i.c, v[7:1]}; end
      SH_SLA:  begin sh_c = v[7]; sh_val = {v[6:0], 1'b0}; end
      SH_SRA:  begin sh_c = v[0]; sh_val = {v[7], v[7:1]}; end
      SH_SWAP: begin sh_c = 1'b0; sh_val = {v[3:0], v[7:4]}; end
      default: begin sh_c = v[0]; sh_val = {1'b0, v[7:1]}; end
    endcase
  end

  always_comb begin
    result_o.value      = v;
    result_o.write_back = 1'b1;
    result_o.flags      = flags_i;
    case (grp)
      GRP_SHIFT: begin
        result_o.value   = sh_val;
        result_o.flags.z = (sh_val == 8'd0);
        result_o.flags.n = 1'b0;
        result_o.flags.h = 1'b0;
        result_o.flags.c = sh_c;
      end
      GRP_BIT: begin
        result_o.write_back = 1'b0;
        result_o.flags.z    = ~v[mid];
        result_o.flags.n    = 1'b0;
        result_o.flags.h    = 1'b1;
      end
      GRP_RES: begin
        result_o.value = v & ~mask;
      end
      default: begin
        result_o.value = v | mask;
      end
    endcase
    result_o.is_mem = (tgt == TargetMem);
    result_o.target = tgt;
    result_o.cycles = (tgt == TargetMem) ? CyclesMem : CyclesReg;
  end

endmodule

// ----- rtl/cb_prefix_bit_op_unit.sv -----
// cb_prefix_bit_op_unit: top level, input register, execute logic, result register.
// Depends on cbpu_pkg and cbpu_exec.
`timescale 1ns / 1ps
// Usage:
//   Drive command_i, operand_value_i and the four flag inputs and raise start_i.
//   A request is taken at a rising edge with start_i high and busy_o low.
//   busy_o is always low: a request may be issued every cycle.
//   The request is captured in an input register; the next cycle the execute
//   logic (shift/rotate mux, bit mask, flag update) evaluates it and the result
//   is captured in the result register.
//   done_o rises as the result register is loaded and is held for exactly one
//   cycle; the result is taken at the edge that ends that strobe cycle.
//   Throughput: one request per cycle, set by the single register-to-register
//   execute path.
//   The receiver cannot stall; each result must be taken in its strobe cycle.
//   Reset clears the request and result valid flags; no results are pending
//   after reset.
module cb_prefix_bit_op_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] command_i,
  input  logic [7:0] operand_value_i,
  input  logic       zero_flag_in_i,
  input  logic       subtract_flag_in_i,
  input  logic       half_flag_in_i,
  input  logic       carry_flag_in_i,
  output logic       done_o,
  output logic [7:0] result_value_o,
  output logic       write_back_o,
  output logic       target_is_memory_o,
  output logic [2:0] target_register_o,
  output logic       zero_flag_out_o,
  output logic       subtract_flag_out_o,
  output logic       half_flag_out_o,
  output logic       carry_flag_out_o,
  output logic [4:0] cycle_count_o
);
  import cbpu_pkg::*;

  logic       in_vld_q;
  logic [7:0] cmd_q;
  logic [7:0] opd_q;
  flags_t     flags_q;
  logic       out_vld_q;
  result_t    res_d;
  result_t    res_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cmd_q   <= command_i;
      opd_q   <= operand_value_i;
      flags_q <= '{z: zero_flag_in_i, n: subtract_flag_in_i,
                   h: half_flag_in_i, c: carry_flag_in_i};
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  cbpu_exec u_exec (
    .command_i (cmd_q),
    .operand_i (opd_q),
    .flags_i   (flags_q),
    .result_o  (res_d)
  );

  assign done_o              = out_vld_q;
  assign result_value_o      = res_q.value;
  assign write_back_o        = res_q.write_back;
  assign target_is_memory_o  = res_q.is_mem;
  assign target_register_o   = res_q.target;
  assign zero_flag_out_o     = res_q.flags.z;
  assign subtract_flag_out_o = res_q.flags.n;
  assign half_flag_out_o     = res_q.flags.h;
  assign carry_flag_out_o    = res_q.flags.c;
  assign cycle_count_o       = res_q.cycles;

endmodule

// ----- test/cbpu_result_checker.sv -----
// cbpu_result_checker: predicts each CB-prefix request and compares it with the result.
// Watches the request and result ports of cb_prefix_bit_op_unit; depends on cbpu_pkg.
`timescale 1ns / 1ps
module cbpu_result_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_o,
  input  logic [7:0] command_i,
  input  logic [7:0] operand_value_i,
  input  logic       zero_flag_in_i,
  input  logic       subtract_flag_in_i,
  input  logic       half_flag_in_i,
  input  logic       carry_flag_in_i,
  input  logic       done_o,
  input  logic [7:0] result_value_o,
  input  logic       write_back_o,
  input  logic       target_is_memory_o,
  input  logic [2:0] target_register_o,
  input  logic       zero_flag_out_o,
  input  logic       subtract_flag_out_o,
  input  logic       half_flag_out_o,
  input  logic       carry_flag_out_o,
  input  logic [4:0] cycle_count_o,
  output int         fail_count_o,
  output int         pending_count_o
);
  import cbpu_pkg::*;

  result_t queued_cb_results[$];
  result_t oldest_result;
  int      mismatches;

  function automatic result_t execute_cb_op(logic [7:0] cmd, logic [7:0] val, flags_t fin);
    result_t   r;
    grp_e      grp;
    shift_op_e sop;
    logic [2:0] idx;
    logic      cout;
    grp          = grp_e'(cmd[7:6]);
    idx          = cmd[5:3];
    sop          = shift_op_e'(idx);
    cout         = 1'b0;
    r.value      = val;
    r.write_back = 1'b1;
    r.is_mem     = (cmd[2:0] == TargetMem);
    r.target     = cmd[2:0];
    r.flags      = fin;
    r.cycles     = r.is_mem ? CyclesMem : CyclesReg;
    case (grp)
      GRP_SHIFT: begin
        case (sop)
          SH_RLC: begin
            cout    = val[7];
            r.value = {val[6:0], val[7]};
          end
          SH_RRC: begin
            cout    = val[0];
            r.value = {val[0], val[7:1]};
          end
          SH_RL: begin
            cout    = val[7];
            r.value = {val[6:0], fin.c};
          end
          SH_RR: begin
            cout    = val[0];
            r.value = {fin.c, val[7:1]};
          end
          SH_SLA: begin
            cout    = val[7];
            r.value = {val[6:0], 1'b0};
          end
          SH_SRA: begin
            cout    = val[0];
            r.value = {val[7], val[7:1]};
          end
          SH_SWAP: begin
            cout    = 1'b0;
            r.value = {val[3:0], val[7:4]};
          end
          default: begin
            cout    = val[0];
            r.value = {1'b0, val[7:1]};
          end
        endcase
        r.flags.z = (r.value == 8'h00);
        r.flags.n = 1'b0;
        r.flags.h = 1'b0;
        r.flags.c = cout;
      end
      GRP_BIT: begin
        r.write_back = 1'b0;
        r.flags.z    = ~val[idx];
        r.flags.n    = 1'b0;
        r.flags.h    = 1'b1;
      end
      GRP_RES: r.value[idx] = 1'b0;
      default: r.value[idx] = 1'b1;
    endcase
    return r;
  endfunction

  function automatic int field_mismatch(string fname, logic [7:0] expv, logic [7:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, expv, actv);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_cb_results.delete();
      fail_count_o    <= 0;
      pending_count_o <= 0;
    end else begin
      mismatches = 0;
      if (done_o) begin
        if (queued_cb_results.size() == 0) begin
          $error("result strobe with no request outstanding");
          mismatches++;
        end else begin
          oldest_result = queued_cb_results.pop_front();
          mismatches += field_mismatch("result_value", oldest_result.value, result_value_o);
          mismatches += field_mismatch("write_back", 8'(oldest_result.write_back),
                                       8'(write_back_o));
          mismatches += field_mismatch("target_is_memory", 8'(oldest_result.is_mem),
                                       8'(target_is_memory_o));
          mismatches += field_mismatch("target_register", 8'(oldest_result.target),
                                       8'(target_register_o));
          mismatches += field_mismatch("zero_flag_out", 8'(oldest_result.flags.z),
                                       8'(zero_flag_out_o));
          mismatches += field_mismatch("subtract_flag_out", 8'(oldest_result.flags.n),
                                       8'(subtract_flag_out_o));
          mismatches += field_mismatch("half_flag_out", 8'(oldest_result.flags.h),
                                       8'(half_flag_out_o));
          mismatches += field_mismatch("carry_flag_out", 8'(oldest_result.flags.c),
                                       8'(carry_flag_out_o));
          mismatches += field_mismatch("cycle_count", 8'(oldest_result.cycles),
                                       8'(cycle_count_o));
        end
      end
      if (start_i && !busy_o) begin
        queued_cb_results.push_back(execute_cb_op(command_i, operand_value_i,
            '{z: zero_flag_in_i, n: subtract_flag_in_i, h: half_flag_in_i, c: carry_flag_in_i}));
      end
      fail_count_o    <= fail_count_o + mismatches;
      pending_count_o <= queued_cb_results.size();
    end
  end

endmodule

// ----- test/cb_prefix_bit_op_unit_test.sv -----
// cb_prefix_bit_op_unit_test: drives directed and random CB-prefix requests with idle phases.
// Depends on cbpu_pkg, cb_prefix_bit_op_unit and cbpu_result_checker.
`timescale 1ns / 1ps
module cb_prefix_bit_op_unit_test;
  import cbpu_pkg::*;

  localparam int WatchdogLimit = 500;
  localparam int RandomRequests = 1900;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  logic [7:0] command_i = 8'h00;
  logic [7:0] operand_value_i = 8'h00;
  logic       zero_flag_in_i = 1'b0;
  logic       subtract_flag_in_i = 1'b0;
  logic       half_flag_in_i = 1'b0;
  logic       carry_flag_in_i = 1'b0;
  logic       done_o;
  logic [7:0] result_value_o;
  logic       write_back_o;
  logic       target_is_memory_o;
  logic [2:0] target_register_o;
  logic       zero_flag_out_o;
  logic       subtract_flag_out_o;
  logic       half_flag_out_o;
  logic       carry_flag_out_o;
  logic [4:0] cycle_count_o;
  int         fail_count;
  int         pending_count;
  int         idle_pct = 0;
  int         stalled_cycles = 0;

  always #10 clk_i = ~clk_i;

  cb_prefix_bit_op_unit i_dut (.*);

  cbpu_result_checker i_checker (
    .*,
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stalled_cycles <= 0;
      end else if (stalled_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
    end
  end

  // flg is {Z, N, H, C}
  task automatic issue_request(logic [7:0] cmd, logic [7:0] val, logic [3:0] flg);
    start_i            <= 1'b1;
    command_i          <= cmd;
    operand_value_i    <= val;
    zero_flag_in_i     <= flg[3];
    subtract_flag_in_i <= flg[2];
    half_flag_in_i     <= flg[1];
    carry_flag_in_i    <= flg[0];
    do @(posedge clk_i); while (busy_o);
    if ($urandom_range(99) < idle_pct) begin
      start_i         <= 1'b0;
      command_i       <= 8'($urandom_range(255));
      operand_value_i <= 8'($urandom_range(255));
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_requests();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] val;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // shifts: carry out, zero result, carry in, swap clearing C
    issue_request({GRP_SHIFT, SH_RLC, 3'd0}, 8'h80, 4'b0000);
    issue_request({GRP_SHIFT, SH_RRC, 3'd1}, 8'h01, 4'b1110);
    issue_request({GRP_SHIFT, SH_RL, 3'd2}, 8'h80, 4'b0000);
    issue_request({GRP_SHIFT, SH_RL, 3'd3}, 8'h7f, 4'b0001);
    issue_request({GRP_SHIFT, SH_RR, 3'd4}, 8'h01, 4'b0001);
    issue_request({GRP_SHIFT, SH_SLA, 3'd5}, 8'h80, 4'b0111);
    issue_request({GRP_SHIFT, SH_SRA, TargetMem}, 8'h81, 4'b0000);
    issue_request({GRP_SHIFT, SH_SWAP, 3'd7}, 8'hf0, 4'b1111);
    issue_request({GRP_SHIFT, SH_SWAP, 3'd0}, 8'h00, 4'b0001);
    issue_request({GRP_SHIFT, SH_SRL, 3'd1}, 8'h01, 4'b0000);
    // bit test: zero and nonzero, memory target
    issue_request({GRP_BIT, 3'd7, 3'd2}, 8'h7f, 4'b0001);
    issue_request({GRP_BIT, 3'd0, TargetMem}, 8'h01, 4'b1110);
    // res / set keep all flags
    issue_request({GRP_RES, 3'd7, 3'd3}, 8'hff, 4'b1111);
    issue_request({GRP_RES, 3'd0, TargetMem}, 8'h00, 4'b0000);
    issue_request({GRP_SET, 3'd0, 3'd4}, 8'h00, 4'b1010);
    issue_request({GRP_SET, 3'd7, TargetMem}, 8'hff, 4'b0101);
    issue_request(8'h00, 8'h00, 4'b0000);
    issue_request(8'hff, 8'hff, 4'b1111);
    drain_requests();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 68;
        3:       idle_pct = 12;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < RandomRequests / 4; i++) begin
        case ($urandom_range(4))
          0:       val = 8'h00;
          1:       val = 8'hff;
          2:       val = 8'h01 << $urandom_range(7);
          3:       val = ~(8'h01 << $urandom_range(7));
          default: val = 8'($urandom_range(255));
        endcase
        issue_request(8'($urandom_range(255)), val, 4'($urandom_range(15)));
      end
      drain_requests();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- cb_prefix_bit_op_unit.f -----
rtl/cbpu_pkg.sv
rtl/cbpu_exec.sv
rtl/cb_prefix_bit_op_unit.sv
test/cbpu_result_checker.sv
test/cb_prefix_bit_op_unit_test.sv
